>>> design/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, switched off while reset is high.
`define ASSERT_SYNC(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, also checked during reset.
`define ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

>>> design/ptsu_pkg.sv
// Types and constants of the periodic timer slot scheduler.
`timescale 1ns / 1ps
package ptsu_pkg;

  localparam int REQ_W     = 2;
  localparam int KIND_W    = 2;
  localparam int TASK_W    = 8;
  localparam int TIME_W    = 32;
  localparam int ELAPSED_W = 16;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SCHEDULE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CANCEL   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_PURGE    = 2'd3;

  // Result codes.
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

  // One timer slot as held in the slot memory.
  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] reload;
  } slot_entry_t;

  // Result of the shared saturating subtractor.
  typedef struct packed {
    logic [TIME_W-1:0] diff;
    logic              zero;
  } sat_sub_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

endpackage

>>> design/ptsu_ifs.sv
// Request and result channel interfaces of the timer slot scheduler.
`timescale 1ns / 1ps
interface ptsu_req_if import ptsu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [TASK_W-1:0]    task_id;
  logic [TIME_W-1:0]    first_delay;
  logic [TIME_W-1:0]    reload_period;
  logic [ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, req_type, task_id, first_delay, reload_period, elapsed_ms,
                  input ready);
  modport sink (input valid, req_type, task_id, first_delay, reload_period, elapsed_ms,
                output ready);
endinterface

interface ptsu_res_if import ptsu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [TASK_W-1:0] expired_task;
  logic              last_result;

  modport source (output valid, result_kind, expired_task, last_result, input ready);
  modport sink (input valid, result_kind, expired_task, last_result, output ready);
endinterface

>>> design/ptsu_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module ptsu_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/ptsu_sat_sub.sv
// Shared saturating subtractor: remaining delay minus elapsed time, clamped at zero.
`timescale 1ns / 1ps
module ptsu_sat_sub import ptsu_pkg::*; (
  input  logic [TIME_W-1:0]    minuend,
  input  logic [ELAPSED_W-1:0] subtrahend,
  output sat_sub_t             res
);

  logic [TIME_W:0] wide;
  logic            above;

  always_comb begin
    wide      = {1'b0, minuend} - {{(TIME_W + 1 - ELAPSED_W){1'b0}}, subtrahend};
    above     = !wide[TIME_W] && (wide[TIME_W-1:0] != '0);
    res.diff  = above ? wide[TIME_W-1:0] : '0;
    res.zero  = !above;
  end

endmodule

>>> design/periodic_timer_slot_scheduler_unit.sv
// Top level of the periodic timer slot scheduler: sequencer, slot table and result register.
// Tick and schedule requests walk the slots one slot per cycle through the single read port
// of the slot memory, between the accept in the idle state and the final beat of the finish
// state; the walk holds on a slot whose expiry beat waits on a full result register. Cancel
// and purge go from accept straight to the finish state. Synchronous active-high reset frees
// every slot.
`timescale 1ns / 1ps
module periodic_timer_slot_scheduler_unit import ptsu_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  ptsu_req_if.sink  req,
  ptsu_res_if.source res
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // Sequencer state and walk position.
  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] idx;

  // Per-slot flags in flip-flops: slot in use, and remaining delay at zero.
  // The zero flag lets purge and the drop step of schedule finish
  // without reading the slot memory.
  logic [NUM_SLOTS-1:0] used;
  logic [NUM_SLOTS-1:0] zero;

  // Request held for the length of its walk.
  logic [REQ_W-1:0]     req_kind;
  logic [TASK_W-1:0]    req_task;
  logic [TIME_W-1:0]    req_delay;
  logic [TIME_W-1:0]    req_period;
  logic [ELAPSED_W-1:0] req_elapsed;

  // Schedule search results, built up one slot per cycle.
  logic             dup;
  logic             found;
  logic [IDX_W-1:0] free_idx;

  // Result register: it parts the sequencer from the downstream consumer.
  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [TASK_W-1:0] out_task;
  logic              out_last;

  logic              load_out;
  logic [KIND_W-1:0] out_kind_next;
  logic [TASK_W-1:0] out_task_next;
  logic              out_last_next;

  // Slot memory ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_entry_t      ram_wdata;
  logic [IDX_W-1:0] rd_addr;
  slot_entry_t      entry;

  sat_sub_t    sub;
  slot_entry_t entry_upd;
  slot_entry_t entry_new;

  logic accept;
  logic out_free;
  logic is_tick;
  logic is_sched;
  logic sched_ok;
  logic need_emit;
  logic step;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || res.ready;
  assign is_tick  = (req_kind == REQ_TICK);
  assign is_sched = (req_kind == REQ_SCHEDULE);
  assign sched_ok = found && !dup;

  assign res.valid        = out_valid;
  assign res.result_kind  = out_kind;
  assign res.expired_task = out_task;
  assign res.last_result  = out_last;

  // The memory holds task, remaining delay and reload period of every slot. Its read
  // data is registered, so the address for slot i+1 is issued while slot i is evaluated.
  ptsu_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (entry)
  );

  // The one subtract-and-compare unit, reused for every slot of a tick.
  ptsu_sat_sub u_sub (
    .minuend    (entry.remaining),
    .subtrahend (req_elapsed),
    .res        (sub)
  );

  // Slot after a tick: an expired slot reloads its period, any other keeps the
  // decremented delay.
  always_comb begin
    entry_upd.task_id   = entry.task_id;
    entry_upd.remaining = need_emit ? entry.reload : sub.diff;
    entry_upd.reload    = entry.reload;
    entry_new.task_id   = req_task;
    entry_new.remaining = req_delay;
    entry_new.reload    = req_period;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer. In the walk state the memory output holds slot idx. A slot that
  // expires needs the result register; if that is still full, the walk holds on
  // the same slot and keeps re-reading it until the beat can be loaded.
  always_comb begin
    state_next    = state;
    req.ready     = 1'b0;
    load_out      = 1'b0;
    out_kind_next = KIND_DONE;
    out_task_next = '0;
    out_last_next = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx;
    ram_wdata     = entry_upd;
    rd_addr       = '0;
    need_emit     = 1'b0;
    step          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.req_type == REQ_TICK || req.req_type == REQ_SCHEDULE) begin
            state_next = ST_WALK;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        need_emit = is_tick && used[idx] && sub.zero;
        step      = !need_emit || out_free;
        if (step) begin
          rd_addr = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
          ram_we  = is_tick && used[idx];
          if (need_emit) begin
            load_out      = 1'b1;
            out_kind_next = KIND_EXPIRED;
            out_task_next = entry.task_id;
          end
          if (idx == LAST_IDX) begin
            state_next = ST_FINISH;
          end
        end else begin
          rd_addr = idx;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_last_next = 1'b1;
          state_next    = ST_IDLE;
          if (is_sched) begin
            out_kind_next = sched_ok ? KIND_ACCEPTED : KIND_REJECTED;
            ram_we        = sched_ok;
            ram_waddr     = free_idx;
            ram_wdata     = entry_new;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Request capture and walk counter.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind    <= req.req_type;
      req_task    <= req.task_id;
      req_delay   <= req.first_delay;
      req_period  <= req.reload_period;
      req_elapsed <= req.elapsed_ms;
    end
    if (accept) begin
      idx <= '0;
    end else if (state == ST_WALK && step) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Slot flags. Schedule and purge first drop every used slot whose delay is at
  // zero; cancel frees everything. The stored contents of a freed slot are never
  // read again before it is filled, so they are left as they are.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      zero <= '0;
    end else if (accept) begin
      if (req.req_type == REQ_CANCEL) begin
        used <= '0;
      end else if (req.req_type != REQ_TICK) begin
        used <= used & ~zero;
      end
    end else if (state == ST_WALK && step && is_tick && used[idx]) begin
      // After a tick a kept slot always holds a nonzero delay.
      zero[idx] <= 1'b0;
      if (need_emit && entry.reload == '0) begin
        used[idx] <= 1'b0;
      end
    end else if (state == ST_FINISH && out_free && is_sched && sched_ok) begin
      used[free_idx] <= 1'b1;
      zero[free_idx] <= (req_delay == '0);
    end
  end

  // Schedule search: any used slot with the same task rejects the request, and the
  // lowest free slot is remembered as the target.
  always_ff @(posedge clk) begin
    if (rst) begin
      dup   <= 1'b0;
      found <= 1'b0;
    end else if (accept) begin
      dup   <= 1'b0;
      found <= 1'b0;
    end else if (state == ST_WALK && is_sched) begin
      if (used[idx]) begin
        if (entry.task_id == req_task) begin
          dup <= 1'b1;
        end
      end else if (!found) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WALK && is_sched && !used[idx] && !found) begin
      free_idx <= idx;
    end
  end

  // Result register: loaded when free or being drained in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind <= out_kind_next;
      out_task <= out_task_next;
      out_last <= out_last_next;
    end
  end

endmodule

>>> design/ptsu_checker.sv
// Port-level checker of the timer slot scheduler and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptsu_checker import ptsu_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [KIND_W-1:0] result_kind,
  input logic [TASK_W-1:0] expired_task,
  input logic              last_result
);

  logic                       req_beat;
  logic                       res_stall;
  logic                       expiry_beat;
  logic                       fields_ok;
  logic [KIND_W+TASK_W+1:0]   res_beat;

  assign req_beat    = req_valid && req_ready;
  assign res_stall   = res_valid && !res_ready;
  assign expiry_beat = (result_kind == KIND_EXPIRED);
  assign fields_ok   = (last_result == !expiry_beat) && (expiry_beat || expired_task == '0);
  assign res_beat    = {res_valid, result_kind, expired_task, last_result};

  // Reset empties the result register.
  `ASSERT_ALWAYS(a_reset_clears_result, clk, rst |=> !res_valid, "result valid after reset")

  // An accepted request keeps the block busy for at least the next cycle.
  `ASSERT_SYNC(a_busy_after_accept, clk, rst, req_beat |=> !req_ready, "ready right after accept")

  // Only expiry beats carry a task id, and exactly the other beats close a request.
  `ASSERT_SYNC(a_kind_fields, clk, rst, res_valid |-> fields_ok, "result fields do not match kind")

  // A stalled result beat holds, valid included.
  `ASSERT_SYNC(a_result_hold, clk, rst, res_stall |=> $stable(res_beat), "stalled result changed")

endmodule

bind periodic_timer_slot_scheduler_unit ptsu_checker u_ptsu_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .result_kind  (res.result_kind),
  .expired_task (res.expired_task),
  .last_result  (res.last_result)
);

>>> tb/ptsu_result_checker.sv
// Checker that predicts the timer slot scheduler's result beats and compares them.
`timescale 1ns / 1ps
module ptsu_result_checker import ptsu_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  ptsu_req_if        req,
  ptsu_res_if        res,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] tid;
    logic              last;
  } outcome_t;

  // Result beats still owed by the block, oldest first.
  outcome_t awaited[$];

  // Shadow copy of the slot table.
  logic              busy[NUM_SLOTS];
  logic [TASK_W-1:0] owner[NUM_SLOTS];
  logic [TIME_W-1:0] countdown[NUM_SLOTS];
  logic [TIME_W-1:0] period[NUM_SLOTS];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // A used slot whose countdown is already zero is no longer running.
  task automatic drop_stopped();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (busy[i] && countdown[i] == '0) busy[i] = 1'b0;
    end
  endtask

  task automatic apply_request(input logic [REQ_W-1:0] op, input logic [TASK_W-1:0] tid,
                               input logic [TIME_W-1:0] delay,
                               input logic [TIME_W-1:0] reload,
                               input logic [ELAPSED_W-1:0] elapsed);
    int                free_idx;
    logic              dup;
    logic [TIME_W-1:0] span;
    free_idx = -1;
    dup      = 1'b0;
    span     = {{(TIME_W-ELAPSED_W){1'b0}}, elapsed};
    case (op)
      REQ_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (busy[i]) begin
            if (countdown[i] > span) countdown[i] = countdown[i] - span;
            else countdown[i] = '0;
            if (countdown[i] == '0) begin
              awaited.push_back('{KIND_EXPIRED, owner[i], 1'b0});
              if (period[i] != '0) countdown[i] = period[i];
              else busy[i] = 1'b0;
            end
          end
        end
        awaited.push_back('{KIND_DONE, '0, 1'b1});
      end
      REQ_SCHEDULE: begin
        drop_stopped();
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (busy[i]) begin
            if (owner[i] == tid) dup = 1'b1;
          end else if (free_idx < 0) begin
            free_idx = i;
          end
        end
        if (dup || free_idx < 0) begin
          awaited.push_back('{KIND_REJECTED, '0, 1'b1});
        end else begin
          busy[free_idx]      = 1'b1;
          owner[free_idx]     = tid;
          countdown[free_idx] = delay;
          period[free_idx]    = reload;
          awaited.push_back('{KIND_ACCEPTED, '0, 1'b1});
        end
      end
      REQ_CANCEL: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          busy[i]      = 1'b0;
          countdown[i] = '0;
          period[i]    = '0;
        end
        awaited.push_back('{KIND_DONE, '0, 1'b1});
      end
      default: begin
        drop_stopped();
        awaited.push_back('{KIND_DONE, '0, 1'b1});
      end
    endcase
  endtask

  task automatic report_field(input string what, input int want, input int got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    outcome_t got;
    if (rst) begin
      awaited.delete();
      for (int i = 0; i < NUM_SLOTS; i++) busy[i] = 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        apply_request(req.req_type, req.task_id, req.first_delay, req.reload_period,
                      req.elapsed_ms);
      end
      if (res.valid && res.ready) begin
        got = '{res.result_kind, res.expired_task, res.last_result};
        if (awaited.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, got kind %0d task %0d last %0d",
                   $time, got.kind, got.tid, got.last);
        end else begin
          want = awaited.pop_front();
          if (got.kind !== want.kind) report_field("result_kind", want.kind, got.kind);
          if (got.tid !== want.tid) report_field("expired_task", want.tid, got.tid);
          if (got.last !== want.last) report_field("last_result", want.last, got.last);
        end
      end
    end
    outstanding = awaited.size();
  end

endmodule

>>> tb/tb_periodic_timer_slot_scheduler_unit.sv
// Testbench top for the periodic timer slot scheduler: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_periodic_timer_slot_scheduler_unit;
  import ptsu_pkg::*;

  localparam int NUM_SLOTS    = 16;
  // Number of random request beats after the directed opening.
  localparam int RANDOM_ITEMS = 420;
  // Cycles with no beat on either channel before the run is declared hung. The slowest
  // legal stretch is a long sender gap, a slot walk and a long receiver stall, so this
  // limit leaves a wide margin.
  localparam int STALL_LIMIT  = 1000;
  // Quiet time after the last expected result, to catch stray extra beats.
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   idle_cycles = 0;
  int   items_sent  = 0;
  int   stall_left  = 0;
  bit   src_gaps_on;
  bit   sink_stalls_on = 1'b1;

  ptsu_req_if req_ch ();
  ptsu_res_if res_ch ();

  periodic_timer_slot_scheduler_unit #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // The checker only watches both channels; it owns the prediction and the comparison.
  ptsu_result_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // 2 ns clock: low for 1 ns, then high for 1 ns.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Idle length for either side: mostly none or a few cycles, now and then a long one.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side back-pressure. The ready line changes only on the falling edge. Stalls
  // come and go in phases, so some stretches see a receiver that never stalls, and the
  // stall start is random relative to the slot walk, hitting expiry beats at any slot.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= 1'b1;
      if (sink_stalls_on && $urandom_range(0, 3) == 0) stall_left = gap_cycles();
    end
    if ($urandom_range(0, 199) == 0) sink_stalls_on = !sink_stalls_on;
  end

  // Hang detector: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one request beat and returns on the falling edge after it was taken. An
  // optional gap with valid low comes first; with no gap, valid simply stays high into
  // the next beat so it never gets two updates in the same time step.
  task automatic put_request(input logic [REQ_W-1:0] op, input logic [TASK_W-1:0] tid,
                             input logic [TIME_W-1:0] delay,
                             input logic [TIME_W-1:0] reload,
                             input logic [ELAPSED_W-1:0] elapsed);
    int gap;
    gap = src_gaps_on ? gap_cycles() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= op;
    req_ch.task_id       <= tid;
    req_ch.first_delay   <= delay;
    req_ch.reload_period <= reload;
    req_ch.elapsed_ms    <= elapsed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  initial begin
    int                   r;
    int                   base;
    logic [REQ_W-1:0]     op;
    logic [TASK_W-1:0]    tid;
    logic [TIME_W-1:0]    delay;
    logic [TIME_W-1:0]    reload;
    logic [ELAPSED_W-1:0] elapsed;

    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_TICK;
    req_ch.task_id       = '0;
    req_ch.first_delay   = '0;
    req_ch.reload_period = '0;
    req_ch.elapsed_ms    = '0;
    res_ch.ready         = 1'b0;
    src_gaps_on          = 1'b1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening. Fields a request does not use carry random junk throughout.
    // A tick on an empty table only reports completion.
    put_request(REQ_TICK, $urandom, $urandom, $urandom, '0);
    // A zero first delay is accepted, and a tick with zero elapsed time expires it.
    put_request(REQ_SCHEDULE, 8'h00, '0, '0, $urandom);
    put_request(REQ_TICK, $urandom, $urandom, $urandom, '0);
    // All-ones task, delay and period; a second request for that task is a duplicate.
    put_request(REQ_SCHEDULE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom);
    put_request(REQ_SCHEDULE, 8'hFF, 32'd5, '0, $urandom);
    // A one-shot and a periodic slot both expire on a maximum tick; the periodic one
    // reloads to one and expires again on the next single-millisecond tick.
    put_request(REQ_SCHEDULE, 8'h01, 32'd1, '0, $urandom);
    put_request(REQ_SCHEDULE, 8'h02, 32'h0000_FFFF, 32'd1, $urandom);
    put_request(REQ_TICK, $urandom, $urandom, $urandom, 16'hFFFF);
    put_request(REQ_TICK, $urandom, $urandom, $urandom, 16'd1);
    // A periodic slot with zero first delay is not running, so purge frees it.
    put_request(REQ_SCHEDULE, 8'h03, '0, 32'd7, $urandom);
    put_request(REQ_PURGE, $urandom, $urandom, $urandom, $urandom);
    // A stopped copy of the same task is dropped before the duplicate check.
    put_request(REQ_SCHEDULE, 8'h05, '0, '0, $urandom);
    put_request(REQ_SCHEDULE, 8'h05, 32'd3, '0, $urandom);
    // Alternating bit patterns on every field.
    put_request(REQ_SCHEDULE, 8'hAA, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555);
    put_request(REQ_SCHEDULE, 8'h55, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA);
    put_request(REQ_TICK, 8'h55, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA);
    // Cancel empties the table; the following tick has nothing to expire.
    put_request(REQ_CANCEL, $urandom, $urandom, $urandom, $urandom);
    put_request(REQ_TICK, $urandom, $urandom, $urandom, '0);

    // Random part. Task ids mostly come from a small pool so duplicates and reuse of
    // freed slots are frequent; short delays and ticks keep expiries coming.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // Full-table sequence: clear, fill every slot, hit the full-table rejection,
        // then one tick that expires all slots and gives the longest result burst.
        put_request(REQ_CANCEL, $urandom, $urandom, $urandom, $urandom);
        base = $urandom_range(0, 255 - NUM_SLOTS);
        for (int k = 0; k <= NUM_SLOTS; k++) begin
          put_request(REQ_SCHEDULE, base + k, $urandom_range(1, 4),
                      $urandom_range(0, 1) ? $urandom_range(1, 9) : 0, $urandom);
        end
        put_request(REQ_TICK, $urandom, $urandom, $urandom, 16'd4);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) op = REQ_TICK;
        else if (r < 87) op = REQ_SCHEDULE;
        else if (r < 97) op = REQ_PURGE;
        else op = REQ_CANCEL;

        tid = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 23);

        r = $urandom_range(0, 9);
        if (r < 2) delay = '0;
        else if (r < 7) delay = $urandom_range(1, 10);
        else if (r < 9) delay = $urandom_range(11, 1000);
        else delay = $urandom;

        r = $urandom_range(0, 9);
        if (r < 4) reload = '0;
        else if (r < 8) reload = $urandom_range(1, 10);
        else reload = $urandom;

        r = $urandom_range(0, 19);
        if (r < 17) elapsed = $urandom_range(0, 8);
        else if (r < 19) elapsed = $urandom_range(0, 65535);
        else elapsed = 16'hFFFF;

        put_request(op, tid, delay, reload, elapsed);
      end
      // Sender gaps also come in phases, including gap-free bursts.
      if ($urandom_range(0, 29) == 0) src_gaps_on = !src_gaps_on;
    end
    req_ch.valid <= 1'b0;

    // Let every owed result arrive, then stay quiet for a while to catch extra beats.
    // A missing result leaves both channels silent and the hang detector ends the run.
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
